>>> hw/rtl/readout_buffer_hit_deframer_unit_defines.svh
// assertion macros shared by the deframer checker
`ifndef READOUT_BUFFER_HIT_DEFRAMER_UNIT_DEFINES_SVH
`define READOUT_BUFFER_HIT_DEFRAMER_UNIT_DEFINES_SVH

// clocked assertion, off while reset is held
`define RBHD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked assertion that is also checked across reset
`define RBHD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/rbhd_pkg.sv
// shared types and constants of the readout buffer hit deframer
`default_nettype none
package rbhd_pkg;

    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_TYPE,
        PH_BODY,
        PH_CHECK
    } t_phase;

    typedef enum logic [2:0] {
        CLS_EVENT,
        CLS_BCO,
        CLS_FE,
        CLS_HIT,
        CLS_END_GOOD,
        CLS_END_BAD
    } t_cls;

    typedef struct packed {
        t_cls        cls;
        logic [31:0] word;
    } t_entry;

    // result beat payload, lowest field at the bottom
    typedef struct packed {
        logic        pad;
        logic [15:0] hits_in_event;
        logic        noise_flag;
        logic [15:0] event_number;
        logic [15:0] full_bco;
        logic [6:0]  short_bco;
        logic [3:0]  front_end;
        logic [6:0]  channel;
        logic [3:0]  module_number;
        logic [5:0]  chip_number;
        logic [6:0]  amplitude;
        logic [2:0]  adc_code;
    } t_hit_data;

    localparam int unsigned DATA_W = $bits(t_hit_data);

    localparam logic [1:0] KIND_HIT      = 2'd0;
    localparam logic [1:0] KIND_END_GOOD = 2'd1;
    localparam logic [1:0] KIND_END_BAD  = 2'd2;

    localparam logic       REG_HEALTHY_FE  = 1'b0;
    localparam logic       REG_HEALTHY_MOD = 1'b1;
    localparam logic [3:0] HEALTHY_FE_RST  = 4'd4;
    localparam logic [3:0] HEALTHY_MOD_RST = 4'd7;

    localparam logic [31:0] DATA_TYPE    = 32'd102;
    localparam logic [31:0] MIN_LENGTH   = 32'd2;
    localparam logic [15:0] MARK_EVENT   = 16'd1;
    localparam logic [15:0] MARK_BCO     = 16'd2;
    localparam logic [5:0]  CHIP_SPLIT   = 6'd27;
    localparam logic [5:0]  CHIP_OFFSET  = 6'd26;
    localparam logic [5:0]  CHIP_MAX     = 6'd26;
    localparam logic [6:0]  CHAN_MAX     = 7'd126;

    localparam logic [3:0] FE_A = 4'd1;
    localparam logic [3:0] FE_B = 4'd2;
    localparam logic [3:0] FE_C = 4'd4;
    localparam logic [3:0] FE_D = 4'd8;

endpackage
`default_nettype wire

>>> hw/rtl/readout_buffer_hit_deframer_unit.sv
// top level of the readout buffer hit deframer
//
//  channel   dir  handshake                   payload
//  s         in   i_s_tvalid / o_s_tready     i_s_tdata: stream_word
//  m         out  o_m_tvalid / i_m_tready     o_m_tdata: hit fields, o_m_tuser: item_kind
//  cfg       in   i_cfg_we                    i_cfg_addr, i_cfg_data
//
//  one beat per cycle on both sides when neither side stalls
//  a hit or buffer-end result passes from its word through the framer, the queue and the output register
//  reset is synchronous, active low, and clears framing, marker state and the queue
//  the queue holds QUEUE_AW-addressed entries; the input stalls only when it is full
`default_nettype none
module readout_buffer_hit_deframer_unit #(
    parameter int EVENT_COUNT_BITS = 16,
    parameter int QUEUE_AW         = 2
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [31:0]                   i_s_tdata,  // stream_word
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // adc_code, amplitude, chip_number, module_number, channel, front_end,
    // short_bco, full_bco, event_number, noise_flag, hits_in_event, zero pad
    output logic [rbhd_pkg::DATA_W-1:0]        o_m_tdata,
    output logic [1:0]                         o_m_tuser,  // item_kind
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_addr,
    input  wire logic [3:0]                    i_cfg_data
);
    import rbhd_pkg::*;

    logic       w_room, w_push, w_q_valid, w_pop;
    t_entry     w_push_entry, w_q_entry;
    t_hit_data  w_data;
    logic [3:0] r_healthy_fe, r_healthy_mod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_healthy_fe  <= HEALTHY_FE_RST;
            r_healthy_mod <= HEALTHY_MOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_HEALTHY_FE:  r_healthy_fe  <= i_cfg_data;
                REG_HEALTHY_MOD: r_healthy_mod <= i_cfg_data;
                default:         r_healthy_fe  <= r_healthy_fe;
            endcase
        end
    end

    rbhd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_word  (i_s_tdata),
        .i_room  (w_room),
        .o_ready (o_s_tready),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    rbhd_queue #(
        .AW (QUEUE_AW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_room  (w_room),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    rbhd_back #(
        .EVENT_COUNT_BITS (EVENT_COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .i_entry       (w_q_entry),
        .o_pop         (w_pop),
        .i_healthy_fe  (r_healthy_fe),
        .i_healthy_mod (r_healthy_mod),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_kind        (o_m_tuser),
        .o_data        (w_data)
    );

    assign o_m_tdata = w_data;

endmodule
`default_nettype wire

>>> hw/rtl/rbhd_front.sv
// record framer: tracks length and type, classifies body words, checks the xor
`default_nettype none
module rbhd_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [31:0]    i_word,
    input  wire logic           i_room,
    output logic                o_ready,
    output logic                o_push,
    output rbhd_pkg::t_entry    o_entry
);
    import rbhd_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_is_data, n_is_data;
    logic [31:0] r_words_left, n_words_left;
    logic [31:0] r_cksum, n_cksum;
    logic [31:0] w_left_m1, w_left_m2;
    logic        w_accept;

    assign o_ready   = i_room;
    assign w_accept  = i_valid && i_room;
    assign w_left_m1 = r_words_left - 32'd1;
    assign w_left_m2 = r_words_left - 32'd2;

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_LENGTH: n_phase = PH_TYPE;
            PH_TYPE: begin
                if (i_word == DATA_TYPE) begin
                    n_phase = (w_left_m2 != '0) ? PH_BODY : PH_CHECK;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (w_left_m1 == '0) begin
                    n_phase = r_is_data ? PH_CHECK : PH_LENGTH;
                end
            end
            PH_CHECK: n_phase = PH_LENGTH;
            default:  n_phase = PH_LENGTH;
        endcase
    end

    // counters, checksum and classification
    always_comb begin
        n_words_left  = r_words_left;
        n_cksum       = r_cksum;
        n_is_data     = r_is_data;
        o_push        = 1'b0;
        o_entry.word  = i_word;
        o_entry.cls   = CLS_HIT;
        unique case (r_phase)
            PH_LENGTH: begin
                n_words_left = (i_word < MIN_LENGTH) ? MIN_LENGTH : i_word;
            end
            PH_TYPE: begin
                n_cksum = '0;
                if (i_word == DATA_TYPE) begin
                    n_is_data    = 1'b1;
                    n_words_left = w_left_m2;
                end else begin
                    n_is_data    = 1'b0;
                    n_words_left = w_left_m1;
                end
            end
            PH_BODY: begin
                n_words_left = w_left_m1;
                if (r_is_data) begin
                    n_cksum = r_cksum ^ i_word;
                    o_push  = w_accept;
                    priority if (i_word[15:0] == MARK_EVENT) begin
                        o_entry.cls = CLS_EVENT;
                    end else if (i_word[15:0] == MARK_BCO) begin
                        o_entry.cls = CLS_BCO;
                    end else if (i_word[11:0] == '0) begin
                        o_entry.cls = CLS_FE;
                    end else begin
                        o_entry.cls = CLS_HIT;
                    end
                end
            end
            PH_CHECK: begin
                o_push      = w_accept;
                o_entry.cls = (r_cksum == i_word) ? CLS_END_GOOD : CLS_END_BAD;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LENGTH;
            r_is_data    <= 1'b0;
            r_words_left <= '0;
            r_cksum      <= '0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_is_data    <= n_is_data;
            r_words_left <= n_words_left;
            r_cksum      <= n_cksum;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/rbhd_queue.sv
// small first-in first-out queue between the framer and the hit decoder
`default_nettype none
module rbhd_queue #(
    parameter int AW = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire rbhd_pkg::t_entry i_entry,
    output logic                o_room,
    input  wire logic           i_pop,
    output logic                o_valid,
    output rbhd_pkg::t_entry    o_entry
);
    import rbhd_pkg::*;

    localparam int DEPTH = 1 << AW;

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [AW:0]   r_count;
    logic          w_push, w_pop;

    assign o_room  = (r_count != (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rptr];
    assign w_push  = i_push && o_room;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + AW'(1);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/rbhd_back.sv
// hit decoder: marker state, chip and module mapping, noise test, event hit count
`default_nettype none
module rbhd_back #(
    parameter int EVENT_COUNT_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire rbhd_pkg::t_entry        i_entry,
    output logic                         o_pop,
    input  wire logic [3:0]              i_healthy_fe,
    input  wire logic [3:0]              i_healthy_mod,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [1:0]                   o_kind,
    output rbhd_pkg::t_hit_data          o_data
);
    import rbhd_pkg::*;

    localparam int CW = EVENT_COUNT_BITS;

    logic [15:0]   r_event, r_full_bco, r_prev_event;
    logic [3:0]    r_fe, r_module, n_module;
    logic          r_prev_valid;
    logic [CW-1:0] r_count, n_count;
    logic [15:0]   w_count_out;
    logic          r_out_valid;
    logic [1:0]    r_out_kind, n_kind;
    t_hit_data     r_out_data, n_data;
    logic          w_take, w_is_hit, w_emit, w_new_event;
    logic [31:0]   w;
    logic [5:0]    w_raw, w_chip;
    logic          w_hi, w_noise;

    assign w       = i_entry.word;
    assign w_take  = i_valid && (!r_out_valid || i_ready);
    assign o_pop   = w_take;
    assign w_is_hit = (i_entry.cls == CLS_HIT);
    assign w_emit  = w_is_hit || (i_entry.cls == CLS_END_GOOD)
                     || (i_entry.cls == CLS_END_BAD);

    assign w_raw  = w[8:3];
    assign w_hi   = (w_raw >= CHIP_SPLIT);
    assign w_chip = w_hi ? (w_raw - CHIP_OFFSET) : w_raw;

    always_comb begin
        unique case (r_fe)
            FE_A:    n_module = w_hi ? 4'd2 : 4'd1;
            FE_B:    n_module = w_hi ? 4'd4 : 4'd3;
            FE_C:    n_module = w_hi ? 4'd8 : 4'd7;
            FE_D:    n_module = w_hi ? 4'd6 : 4'd5;
            default: n_module = r_module;
        endcase
    end

    assign w_noise = (w[30:24] != '0) || (w_chip == '0) || (w_chip > CHIP_MAX)
                     || (w[15:9] == '0) || (w[15:9] > CHAN_MAX)
                     || (r_fe != i_healthy_fe) || (n_module != i_healthy_mod);

    assign w_new_event = !r_prev_valid || (r_event != r_prev_event);

    always_comb begin
        if (w_new_event) begin
            n_count = CW'(1);
        end else if (r_count != '1) begin
            n_count = r_count + CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    generate
        if (CW > 16) begin : g_sat
            assign w_count_out = (|n_count[CW-1:16]) ? 16'hFFFF : n_count[15:0];
        end else if (CW == 16) begin : g_same
            assign w_count_out = n_count;
        end else begin : g_ext
            assign w_count_out = {{(16-CW){1'b0}}, n_count};
        end
    endgenerate

    always_comb begin
        n_data = '0;
        n_kind = KIND_HIT;
        unique case (i_entry.cls)
            CLS_END_GOOD: n_kind = KIND_END_GOOD;
            CLS_END_BAD:  n_kind = KIND_END_BAD;
            default: begin
                n_kind               = KIND_HIT;
                n_data.adc_code      = w[2:0];
                n_data.amplitude     = w[30:24];
                n_data.chip_number   = w_chip;
                n_data.module_number = n_module;
                n_data.channel       = w[15:9];
                n_data.front_end     = r_fe;
                n_data.short_bco     = w[22:16];
                n_data.full_bco      = r_full_bco;
                n_data.event_number  = r_event;
                n_data.noise_flag    = w_noise;
                n_data.hits_in_event = w_count_out;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event      <= '0;
            r_full_bco   <= '0;
            r_fe         <= '0;
            r_module     <= '0;
            r_prev_event <= '0;
            r_prev_valid <= 1'b0;
            r_count      <= '0;
        end else if (w_take) begin
            unique case (i_entry.cls)
                CLS_EVENT: r_event    <= w[31:16];
                CLS_BCO:   r_full_bco <= w[31:16];
                CLS_FE:    r_fe       <= w[15:12];
                CLS_HIT: begin
                    r_module     <= n_module;
                    r_count      <= n_count;
                    r_prev_event <= r_event;
                    r_prev_valid <= 1'b1;
                end
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_emit) begin
            r_out_kind <= n_kind;
            r_out_data <= n_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_data  = r_out_data;

endmodule
`default_nettype wire

>>> hw/rtl/rbhd_checker.sv
// port-level checks of the deframer, bound to the top level
`default_nettype none
`include "readout_buffer_hit_deframer_unit_defines.svh"
module rbhd_checker (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [rbhd_pkg::DATA_W-1:0] o_m_tdata,
    input wire logic [1:0]             o_m_tuser
);
    import rbhd_pkg::*;

    t_hit_data                 w_d;
    logic [rbhd_pkg::DATA_W+2:0] w_beat;
    logic                      w_stall, w_hit_beat, w_end_beat, w_clean, w_clean_ok, w_count_ok;

    assign w_d        = o_m_tdata;
    assign w_beat     = {o_m_tvalid, o_m_tuser, o_m_tdata};
    assign w_stall    = o_m_tvalid && !i_m_tready;
    assign w_hit_beat = o_m_tvalid && (o_m_tuser == KIND_HIT);
    assign w_end_beat = o_m_tvalid && (o_m_tuser != KIND_HIT);
    assign w_clean    = w_hit_beat && !w_d.noise_flag;
    assign w_clean_ok = (w_d.amplitude == '0) && (w_d.chip_number != '0)
                        && (w_d.chip_number <= CHIP_MAX);
    assign w_count_ok = (w_d.hits_in_event != '0);

    `RBHD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_tvalid, "valid after reset")
    `RBHD_ASSERT(a_stall_hold, i_clk, i_rst_n, w_stall |=> $stable(w_beat), "stalled beat changed")
    `RBHD_ASSERT(a_end_zero, i_clk, i_rst_n, w_end_beat |-> o_m_tdata == '0, "end beat not zero")
    `RBHD_ASSERT(a_clean_hit, i_clk, i_rst_n, w_clean |-> w_clean_ok, "clean hit out of range")
    `RBHD_ASSERT(a_count_live, i_clk, i_rst_n, w_hit_beat |-> w_count_ok, "zero event count")

endmodule

bind readout_buffer_hit_deframer_unit rbhd_checker u_rbhd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire

>>> test/readout_buffer_hit_deframer_unit_tb.sv
// self-checking testbench of the readout buffer hit deframer with a word-level hit predictor
`timescale 1ns / 1ps
module readout_buffer_hit_deframer_unit_tb;
    import rbhd_pkg::*;

    localparam int          DIR_N        = 24;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          PHASE_ITEMS  = 150;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [31:0] SKIP_TYPE_A  = 32'd100;
    localparam logic [31:0] SKIP_TYPE_B  = 32'd101;
    localparam logic [31:0] HIT_A        = 32'h0000_142F;
    localparam logic [31:0] HIT_B        = 32'h0000_FCD8;
    localparam logic [31:0] EV_MARK_TOP  = {16'hFFFF, MARK_EVENT};
    localparam logic [31:0] BCO_MARK_TOP = {16'hFFFF, MARK_BCO};
    localparam logic [31:0] FE_MARK_C    = {16'h0000, FE_C, 12'h000};
    localparam logic [31:0] FE_MARK_D    = {16'h0000, FE_D, 12'h000};
    localparam logic [31:0] EV_MARK_ZERO = {16'h0000, MARK_EVENT};

    typedef struct packed {
        logic [1:0] kind;
        t_hit_data  data;
    } t_hit_result;

    typedef struct packed {
        logic [31:0] word;
        logic        typed;
        logic [1:0]  kind;
    } t_dir_row;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic [31:0]          i_s_tdata  = '0;
    logic                 i_m_tready = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic                 i_cfg_addr = 1'b0;
    logic [3:0]           i_cfg_data = '0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [DATA_W-1:0]    o_m_tdata;
    logic [1:0]           o_m_tuser;

    readout_buffer_hit_deframer_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [3:0]  healthy_fe  = HEALTHY_FE_RST;
    logic [3:0]  healthy_mod = HEALTHY_MOD_RST;
    t_phase      fr_phase    = PH_LENGTH;
    logic        fr_is_data  = 1'b0;
    logic [31:0] fr_left     = '0;
    logic [31:0] fr_csum     = '0;
    logic [15:0] cur_event   = '0;
    logic [15:0] cur_bco     = '0;
    logic [3:0]  cur_fe      = '0;
    logic [3:0]  cur_mod     = '0;
    logic [15:0] prev_event  = '0;
    logic        prev_valid  = 1'b0;
    logic [15:0] hit_cnt     = '0;

    t_hit_result expected_hits [$];
    t_hit_result want;
    int          fail_cnt   = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int          cycle_cnt  = 0;
    logic [15:0] rdy_tick   = '0;
    logic [15:0] rdy_mask   = 16'hFFFF;

    task automatic deframe_predict(input logic [31:0] w, output bit got, output t_hit_result r);
        logic [5:0] raw;
        logic       hi;
        logic [5:0] chip;
        r   = '0;
        got = 1'b0;
        case (fr_phase)
            PH_LENGTH: begin
                fr_left  = (w < MIN_LENGTH) ? MIN_LENGTH : w;
                fr_phase = PH_TYPE;
            end
            PH_TYPE: begin
                fr_csum    = '0;
                fr_is_data = (w == DATA_TYPE);
                fr_left    = fr_left - (fr_is_data ? 32'd2 : 32'd1);
                if (fr_is_data && fr_left == 32'd0) begin
                    fr_phase = PH_CHECK;
                end else begin
                    fr_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                fr_left = fr_left - 32'd1;
                if (fr_is_data) begin
                    fr_csum = fr_csum ^ w;
                    if (w[15:0] == MARK_EVENT) begin
                        cur_event = w[31:16];
                    end else if (w[15:0] == MARK_BCO) begin
                        cur_bco = w[31:16];
                    end else if (w[11:0] == 12'd0) begin
                        cur_fe = w[15:12];
                    end else begin
                        raw  = w[8:3];
                        hi   = (raw >= CHIP_SPLIT);
                        chip = hi ? raw - CHIP_OFFSET : raw;
                        case (cur_fe)
                            FE_A: cur_mod = hi ? 4'd2 : 4'd1;
                            FE_B: cur_mod = hi ? 4'd4 : 4'd3;
                            FE_C: cur_mod = hi ? 4'd8 : 4'd7;
                            FE_D: cur_mod = hi ? 4'd6 : 4'd5;
                            default: ;
                        endcase
                        if (!prev_valid || cur_event != prev_event) begin
                            hit_cnt    = 16'd1;
                            prev_event = cur_event;
                            prev_valid = 1'b1;
                        end else if (hit_cnt != 16'hFFFF) begin
                            hit_cnt = hit_cnt + 16'd1;
                        end
                        got                    = 1'b1;
                        r.kind                 = KIND_HIT;
                        r.data.adc_code        = w[2:0];
                        r.data.amplitude       = w[30:24];
                        r.data.chip_number     = chip;
                        r.data.module_number   = cur_mod;
                        r.data.channel         = w[15:9];
                        r.data.front_end       = cur_fe;
                        r.data.short_bco       = w[22:16];
                        r.data.full_bco        = cur_bco;
                        r.data.event_number    = cur_event;
                        r.data.noise_flag      = (w[30:24] != 7'd0) || chip == 6'd0
                            || chip > CHIP_MAX || w[15:9] == 7'd0 || w[15:9] > CHAN_MAX
                            || cur_fe != healthy_fe || cur_mod != healthy_mod;
                        r.data.hits_in_event   = hit_cnt;
                    end
                end
                if (fr_left == 32'd0) begin
                    if (fr_is_data) begin
                        fr_phase = PH_CHECK;
                    end else begin
                        fr_phase = PH_LENGTH;
                    end
                end
            end
            default: begin
                got      = 1'b1;
                r.kind   = (fr_csum == w) ? KIND_END_GOOD : KIND_END_BAD;
                fr_phase = PH_LENGTH;
            end
        endcase
    endtask

    function automatic t_dir_row dir_row(input int idx);
        t_dir_row row;
        row = '0;
        case (idx)
            0:  row.word = 32'd0;
            1:  row.word = DATA_TYPE;
            2:  row = '{32'd0, 1'b1, KIND_END_GOOD};
            3:  row.word = 32'd1;
            4:  row.word = DATA_TYPE;
            5:  row = '{32'd5, 1'b1, KIND_END_BAD};
            6:  row.word = 32'd0;
            7:  row.word = SKIP_TYPE_B;
            8:  row.word = 32'hFFFF_FFFF;
            9:  row.word = 32'd8;
            10: row.word = DATA_TYPE;
            // hit before any marker: module never set, no event counted yet
            11: row.word = HIT_A;
            12: row.word = EV_MARK_TOP;
            13: row.word = BCO_MARK_TOP;
            14: row.word = FE_MARK_C;
            15: row.word = HIT_A;
            16: row.word = 32'hFFFF_FFFF;
            17: row = '{HIT_A ^ EV_MARK_TOP ^ BCO_MARK_TOP ^ FE_MARK_C ^ HIT_A ^ 32'hFFFF_FFFF,
                        1'b1, KIND_END_GOOD};
            18: row.word = 32'd5;
            19: row.word = DATA_TYPE;
            20: row.word = FE_MARK_D;
            21: row.word = EV_MARK_ZERO;
            22: row.word = HIT_B;
            default: row = '{32'd0, 1'b1, KIND_END_BAD};
        endcase
        return row;
    endfunction

    function automatic logic [31:0] make_hit();
        logic [31:0] w;
        do begin
            w = $urandom;
            if ($urandom_range(0, 9) < 6) w[30:24] = 7'd0;
            if ($urandom_range(0, 9) < 7) w[8:3] = 6'($urandom_range(1, 52));
            if ($urandom_range(0, 9) < 7) w[15:9] = 7'($urandom_range(1, 126));
        end while (w[11:0] == 12'd0 || w[15:0] == MARK_EVENT || w[15:0] == MARK_BCO);
        return w;
    endfunction

    task automatic send_word(input logic [31:0] w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= w;
        do @(posedge i_clk); while (!o_s_tready);
        burst_left = burst_left - 1;
        items_sent = items_sent + 1;
    endtask

    task automatic stream_word(input logic [31:0] w);
        bit          got;
        t_hit_result r;
        send_word(w);
        deframe_predict(w, got, r);
        if (got) expected_hits.push_back(r);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_cfg(input logic [3:0] fe, input logic [3:0] mod);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= REG_HEALTHY_FE;
        i_cfg_data <= fe;
        @(posedge i_clk);
        healthy_fe = fe;
        i_cfg_addr <= REG_HEALTHY_MOD;
        i_cfg_data <= mod;
        @(posedge i_clk);
        healthy_mod = mod;
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_data_record(input bit broken, input int n);
        logic [31:0] sum;
        logic [31:0] w;
        logic [31:0] len;
        logic [3:0]  fe;
        int          sel;
        len = 32'(n + 2);
        if (n == 0 && $urandom_range(0, 1) == 1) len = 32'($urandom_range(0, 1));
        stream_word(len);
        stream_word(DATA_TYPE);
        sum = '0;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 9);
            case ($urandom_range(0, 4))
                0: fe = FE_A;
                1: fe = FE_B;
                2: fe = FE_C;
                3: fe = FE_D;
                default: fe = 4'($urandom);
            endcase
            if (broken) begin
                w = $urandom;
            end else if (sel == 0) begin
                w = {($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3)),
                     MARK_EVENT};
            end else if (sel == 1) begin
                w = {16'($urandom), MARK_BCO};
            end else if (sel == 2) begin
                w = {16'($urandom), fe, 12'h000};
            end else begin
                w = make_hit();
            end
            sum = sum ^ w;
            stream_word(w);
        end
        if (broken || $urandom_range(0, 7) == 0) sum = sum ^ ($urandom | 32'h0000_0100);
        stream_word(sum);
    endtask

    task automatic send_skip_record();
        logic [31:0] len;
        logic [31:0] kind_word;
        int          skip;
        len = 32'($urandom_range(0, 10));
        case ($urandom_range(0, 2))
            0: kind_word = SKIP_TYPE_A;
            1: kind_word = SKIP_TYPE_B;
            default: kind_word = $urandom;
        endcase
        if (kind_word == DATA_TYPE) kind_word = SKIP_TYPE_A;
        skip = (len < MIN_LENGTH) ? 1 : int'(len) - 1;
        stream_word(len);
        stream_word(kind_word);
        for (int i = 0; i < skip; i++) stream_word($urandom);
    endtask

    always @(posedge i_clk) begin
        rdy_tick <= rdy_tick + 16'd1;
        if (rdy_tick[7:0] == 8'd0) begin
            rdy_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
        end
        i_m_tready <= rdy_mask[rdy_tick[3:0]];
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_hits.size() == 0) begin
                fail_cnt = fail_cnt + 1;
                if (fail_cnt <= MAX_REPORTS) begin
                    $display("unexpected beat: kind %0d data %h", o_m_tuser, o_m_tdata);
                end
            end else begin
                want = expected_hits.pop_front();
                if (o_m_tuser !== want.kind || o_m_tdata !== want.data) begin
                    fail_cnt = fail_cnt + 1;
                    if (fail_cnt <= MAX_REPORTS) begin
                        $display("beat mismatch: expected kind %0d data %h, got kind %0d data %h",
                                 want.kind, want.data, o_m_tuser, o_m_tdata);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        bit          got;
        t_hit_result r;
        t_dir_row    row;
        int          phase_start;
        int          pick;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            row = dir_row(i);
            send_word(row.word);
            deframe_predict(row.word, got, r);
            if (row.typed) begin
                r      = '0;
                r.kind = row.kind;
            end
            if (got) expected_hits.push_back(r);
        end

        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: write_cfg(4'd0, 4'd0);
                1: write_cfg(4'd15, 4'd8);
                2: write_cfg(FE_A, 4'd1);
                3: write_cfg(FE_D, 4'd6);
                4: write_cfg(FE_B, 4'd3);
                default: write_cfg(HEALTHY_FE_RST, HEALTHY_MOD_RST);
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    send_data_record(1'b0,
                                     ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12));
                end else if (pick < 92) begin
                    send_skip_record();
                end else begin
                    send_data_record(1'b1, $urandom_range(0, 8));
                end
            end
        end
        drain();

        if (fail_cnt == 0 && expected_hits.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
